[rtl/core/mstg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mstg_pkg
// Shared types, constants and the note divider table of the stepper tone
// generator.
// ----------------------------------------------------------------------------
package mstg_pkg;

	localparam int CHANNELS   = 10;
	localparam int CH_W       = $clog2(CHANNELS);
	localparam int NOTE_COUNT = 60;
	localparam int NOTE_W     = 6;
	localparam int CHAN_IN_W  = 7;
	localparam int LEVEL_W    = 10;
	localparam int TICK_W     = 31;
	localparam int DIV_W      = 8;
	localparam int CNT_W      = 10;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;
	localparam int DIGITS     = 4;
	localparam int DIG_W      = 2;

	localparam logic [15:0]      INIT_TICKS_RST = 16'd16000;
	localparam logic [7:0]       STEP_LIMIT_RST = 8'd140;
	localparam logic [7:0]       INIT_DIV_RST   = 8'd45;
	localparam logic [CNT_W-1:0] STEP_MAX       = 10'd1023;

	typedef enum logic [1:0] {
		REG_INIT_TICKS = 2'd0,
		REG_STEP_LIMIT = 2'd1,
		REG_INIT_DIV   = 2'd2
	} reg_idx_t;

	localparam logic [DIV_W-1:0] NOTE_ROM [NOTE_COUNT] = '{
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd182, 8'd172, 8'd162, 8'd153, 8'd144, 8'd136, 8'd129, 8'd121, 8'd115,
		8'd108, 8'd102, 8'd96,  8'd91,  8'd86,  8'd81,  8'd76,  8'd72,  8'd68,  8'd64,
		8'd61,  8'd57,  8'd54,  8'd51,  8'd48,  8'd45,  8'd43,  8'd40,  8'd38,  8'd36,
		8'd34,  8'd32,  8'd30,  8'd29,  8'd27,  8'd26,  8'd24,  8'd23,  8'd1,   8'd1
	};

	typedef struct packed {
		logic             load;
		logic             note_apply;
		logic             div_en;
		logic [DIG_W-1:0] digit;
		logic [CH_W-1:0]  chan;
		logic             step_apply;
		logic             fin_apply;
		logic             out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic in_is_note;
	} dp_status_t;

	typedef struct packed {
		logic              we;
		logic [1:0]        idx;
		logic [DATA_W-1:0] data;
	} cfg_bus_t;

endpackage
`default_nettype wire

[rtl/core/mstg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mstg_ctrl
// Sequencer: accepts an item, applies a note or walks the channels through
// the remainder unit for a tick, and hands the result to the output register.
// ----------------------------------------------------------------------------
module mstg_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire mstg_pkg::dp_status_t status,
	output mstg_pkg::dp_cmd_t         cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_NOTE,
		S_DIV,
		S_STEP,
		S_FIN,
		S_OUT
	} state_t;

	state_t                       state_q;
	logic [mstg_pkg::CH_W-1:0]    ch_q;
	logic [mstg_pkg::DIG_W-1:0]   dig_q;
	logic                         out_valid_q;
	logic                         out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.note_apply = (state_q == S_NOTE);
		cmd.div_en     = (state_q == S_DIV);
		cmd.digit      = dig_q;
		cmd.chan       = ch_q;
		cmd.step_apply = (state_q == S_STEP);
		cmd.fin_apply  = (state_q == S_FIN);
		cmd.out_load   = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= '0;
			dig_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					ch_q  <= '0;
					dig_q <= '0;
					if (in_valid)
						state_q <= status.in_is_note ? S_NOTE : S_DIV;
				end
				S_NOTE: state_q <= S_OUT;
				S_DIV: begin
					dig_q <= dig_q + 1'b1;
					if (dig_q == mstg_pkg::DIG_W'(mstg_pkg::DIGITS - 1))
						state_q <= S_STEP;
				end
				S_STEP: begin
					dig_q <= '0;
					if (ch_q == mstg_pkg::CH_W'(mstg_pkg::CHANNELS - 1)) begin
						state_q <= S_FIN;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= S_DIV;
					end
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/core/mstg_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mstg_dp
// Channel state, configuration registers, byte-serial remainder unit and the
// output register.
// ----------------------------------------------------------------------------
module mstg_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire mstg_pkg::dp_cmd_t                   cmd,
	input  wire mstg_pkg::cfg_bus_t                  cfg,
	input  wire logic [1:0]                          rd_idx,
	output logic [mstg_pkg::DATA_W-1:0]              rd_data,
	input  wire logic                                in_cmd,
	input  wire logic [mstg_pkg::NOTE_W-1:0]         in_note,
	input  wire logic [mstg_pkg::CHAN_IN_W-1:0]      in_channel,
	input  wire logic                                in_turn_on,
	output mstg_pkg::dp_status_t                     status,
	output logic [mstg_pkg::LEVEL_W-1:0]             step_levels,
	output logic [mstg_pkg::LEVEL_W-1:0]             dir_levels,
	output logic                                     started
);

	localparam int CH = mstg_pkg::CHANNELS;

	logic [15:0]                    init_ticks_q;
	logic [7:0]                     step_limit_q;
	logic [7:0]                     init_div_q;

	logic [mstg_pkg::TICK_W-1:0]    tick_q;
	logic                           started_q;
	logic [mstg_pkg::DIV_W-1:0]     div_q [CH];
	logic [CH-1:0]                  on_q;
	logic [mstg_pkg::CNT_W-1:0]     cnt_q [CH];
	logic [CH-1:0]                  step_q;
	logic [CH-1:0]                  dir_q;

	logic [mstg_pkg::NOTE_W-1:0]    note_q;
	logic [mstg_pkg::CHAN_IN_W-1:0] chan_q;
	logic                           turn_on_q;

	logic [mstg_pkg::DIV_W-1:0]     rem_q;
	logic [mstg_pkg::DIV_W-1:0]     rem_next;
	logic [mstg_pkg::DIV_W-1:0]     divisor;
	logic [7:0]                     byte_in;
	logic [31:0]                    dividend;
	logic [mstg_pkg::DIG_W-1:0]     byte_sel;

	logic                           fire;
	logic                           flip;
	logic [mstg_pkg::CNT_W-1:0]     cnt_base;
	logic [mstg_pkg::CNT_W-1:0]     cnt_new;
	logic [mstg_pkg::TICK_W-1:0]    tick_next;
	logic                           finish_init;
	logic                           chan_ok;
	logic [mstg_pkg::DIV_W-1:0]     note_div;
	logic [mstg_pkg::CH_W-1:0]      chan_idx;

	assign status.in_is_note = in_cmd;

	always_comb begin
		unique case (rd_idx)
			mstg_pkg::REG_INIT_TICKS: rd_data = {16'd0, init_ticks_q};
			mstg_pkg::REG_STEP_LIMIT: rd_data = {24'd0, step_limit_q};
			mstg_pkg::REG_INIT_DIV:   rd_data = {24'd0, init_div_q};
			default:                  rd_data = '0;
		endcase
	end

	// remainder of tick count by channel divider, one byte per cycle
	assign divisor  = (div_q[cmd.chan] == '0) ? 8'd1 : div_q[cmd.chan];
	assign dividend = {1'b0, tick_q};
	assign byte_sel = mstg_pkg::DIG_W'(mstg_pkg::DIGITS - 1) - cmd.digit;
	assign byte_in  = dividend[8*byte_sel +: 8];

	always_comb begin
		logic [8:0] p;
		logic [7:0] r;
		r = (cmd.digit == '0) ? 8'd0 : rem_q;
		for (int k = 7; k >= 0; k--) begin
			p = {r, byte_in[k]};
			if (p >= {1'b0, divisor})
				p = p - {1'b0, divisor};
			r = p[7:0];
		end
		rem_next = r;
	end

	assign fire     = on_q[cmd.chan] && (rem_q == '0);
	assign flip     = started_q && (cnt_q[cmd.chan] > {2'b00, step_limit_q});
	assign cnt_base = flip ? '0 : cnt_q[cmd.chan];
	assign cnt_new  = (cnt_base < mstg_pkg::STEP_MAX) ? cnt_base + 1'b1 : cnt_base;

	assign tick_next   = tick_q + 1'b1;
	assign finish_init = !started_q && (tick_next > {15'd0, init_ticks_q});

	assign chan_ok  = chan_q < mstg_pkg::CHAN_IN_W'(CH);
	assign chan_idx = chan_q[mstg_pkg::CH_W-1:0];
	assign note_div = (note_q < mstg_pkg::NOTE_W'(mstg_pkg::NOTE_COUNT)) ?
		mstg_pkg::NOTE_ROM[note_q] : 8'd1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			note_q    <= in_note;
			chan_q    <= in_channel;
			turn_on_q <= in_turn_on;
		end
		if (cmd.div_en)
			rem_q <= rem_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_ticks_q <= mstg_pkg::INIT_TICKS_RST;
			step_limit_q <= mstg_pkg::STEP_LIMIT_RST;
			init_div_q   <= mstg_pkg::INIT_DIV_RST;
			tick_q       <= '0;
			started_q    <= 1'b0;
			on_q         <= '1;
			step_q       <= '0;
			dir_q        <= '1;
			for (int i = 0; i < CH; i++) begin
				div_q[i] <= mstg_pkg::INIT_DIV_RST;
				cnt_q[i] <= '0;
			end
			step_levels  <= '0;
			dir_levels   <= '1;
			started      <= 1'b0;
		end else begin
			if (cfg.we) begin
				unique case (cfg.idx)
					mstg_pkg::REG_INIT_TICKS: init_ticks_q <= cfg.data[15:0];
					mstg_pkg::REG_STEP_LIMIT: step_limit_q <= cfg.data[7:0];
					mstg_pkg::REG_INIT_DIV: begin
						init_div_q <= cfg.data[7:0];
						if (!started_q)
							for (int i = 0; i < CH; i++)
								div_q[i] <= cfg.data[7:0];
					end
					default: ;
				endcase
			end
			if (cmd.note_apply && chan_ok) begin
				div_q[chan_idx] <= note_div;
				on_q[chan_idx]  <= turn_on_q;
			end
			if (cmd.step_apply && fire) begin
				step_q[cmd.chan] <= !step_q[cmd.chan];
				if (flip)
					dir_q[cmd.chan] <= !dir_q[cmd.chan];
				cnt_q[cmd.chan] <= cnt_new;
			end
			if (cmd.fin_apply) begin
				tick_q <= tick_next;
				if (finish_init) begin
					started_q <= 1'b1;
					on_q      <= '0;
					dir_q     <= ~dir_q;
					for (int i = 0; i < CH; i++) begin
						div_q[i] <= 8'd1;
						cnt_q[i] <= '0;
					end
				end
			end
			if (cmd.out_load) begin
				step_levels <= step_q;
				dir_levels  <= dir_q;
				started     <= started_q;
			end
		end
	end

endmodule
`default_nettype wire

[rtl/core/multichannel_stepper_tone_generator_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_stepper_tone_generator_unit
// Ten-channel stepper tone generator with APB configuration registers.
// ----------------------------------------------------------------------------
// One item at a time, with one result per item held in an output register so
// the next item can be taken while a result waits. A note command passes
// through a note-apply state to the output state. For a tick, a shared
// remainder unit works through the tick count one byte a cycle, four bytes
// per channel, followed by one update step per channel and a final step for
// the tick count and end-of-startup update. Registers sit at byte addresses
// 0 (init_ticks), 4 (step_limit) and 8 (init_divider).
module multichannel_stepper_tone_generator_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [mstg_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [mstg_pkg::DATA_W-1:0]         pwdata,
	output logic [mstg_pkg::DATA_W-1:0]              prdata,
	output logic                                     pready,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                cmd,
	input  wire logic [mstg_pkg::NOTE_W-1:0]         note,
	input  wire logic [mstg_pkg::CHAN_IN_W-1:0]      channel,
	input  wire logic                                turn_on,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [mstg_pkg::LEVEL_W-1:0]             step_levels,
	output logic [mstg_pkg::LEVEL_W-1:0]             dir_levels,
	output logic                                     started
);

	mstg_pkg::dp_cmd_t    dp_cmd;
	mstg_pkg::dp_status_t dp_status;
	mstg_pkg::cfg_bus_t   cfg;

	assign pready   = 1'b1;
	assign cfg.we   = psel && penable && pwrite;
	assign cfg.idx  = paddr[3:2];
	assign cfg.data = pwdata;

	mstg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	mstg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (dp_cmd),
		.cfg         (cfg),
		.rd_idx      (paddr[3:2]),
		.rd_data     (prdata),
		.in_cmd      (cmd),
		.in_note     (note),
		.in_channel  (channel),
		.in_turn_on  (turn_on),
		.status      (dp_status),
		.step_levels (step_levels),
		.dir_levels  (dir_levels),
		.started     (started)
	);

	// a new item is never taken in the cycle after one was accepted
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in progress");

	// result fields change only when the output register loads
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!dp_cmd.out_load |=> $stable({step_levels, dir_levels, started}))
		else $error("result changed without an output load");

	// startup never restarts
	a_started_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started))
		else $error("started flag cleared");

	// an output load always leaves a valid result
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |=> out_valid)
		else $error("output load without valid result");

endmodule
`default_nettype wire

[dv/multichannel_stepper_tone_generator_unit_test.sv]
// ----------------------------------------------------------------------------
// multichannel_stepper_tone_generator_unit_test
// Self-checking bench for the stepper tone generator. Tick and note items go
// in over a valid/ready channel, and the registers are set over APB between
// phases. A scoreboard object keeps its own copy of the channel state,
// predicts the step and direction levels of every item and checks each
// result against the oldest prediction. The run covers the startup sweep,
// its end and a long random part, randomly gapping both sides after phase 0.
// ----------------------------------------------------------------------------
module multichannel_stepper_tone_generator_unit_test;

	localparam int NCH         = 10;
	localparam int TIMEOUT     = 3000000;
	localparam int RAND_PHASES = 5;
	localparam int PHASE_ITEMS = 270;
	localparam logic [1:0] REG_NONE = 2'd3;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_NOTE = 1'b1;

	localparam logic [7:0] PITCH_DIV [60] = '{
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd1,   8'd182, 8'd172, 8'd162, 8'd153, 8'd144, 8'd136, 8'd129, 8'd121, 8'd115,
		8'd108, 8'd102, 8'd96,  8'd91,  8'd86,  8'd81,  8'd76,  8'd72,  8'd68,  8'd64,
		8'd61,  8'd57,  8'd54,  8'd51,  8'd48,  8'd45,  8'd43,  8'd40,  8'd38,  8'd36,
		8'd34,  8'd32,  8'd30,  8'd29,  8'd27,  8'd26,  8'd24,  8'd23,  8'd1,   8'd1
	};

	typedef struct packed {
		logic [9:0] steps;
		logic [9:0] dirs;
		logic       done;
	} levels_t;

	class tone_scoreboard;
		logic [15:0]  sweep_ticks;
		logic [7:0]   rev_limit;
		logic [7:0]   sweep_div;
		logic [30:0]  tick_cnt;
		logic [7:0]   div_q [NCH];
		logic [9:0]   cnt_q [NCH];
		logic [NCH-1:0] on_q;
		logic [NCH-1:0] step_q;
		logic [NCH-1:0] dir_q;
		logic         swept;
		levels_t      levels_q [$];
		int           errors;

		function new();
			int i;
			sweep_ticks = 16'd16000;
			rev_limit = 8'd140;
			sweep_div = 8'd45;
			tick_cnt = '0;
			swept = 1'b0;
			on_q = '1;
			step_q = '0;
			dir_q = '1;
			errors = 0;
			for (i = 0; i < NCH; i++) begin
				div_q[i] = sweep_div;
				cnt_q[i] = '0;
			end
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			int i;
			case (idx)
				mstg_pkg::REG_INIT_TICKS: sweep_ticks = value[15:0];
				mstg_pkg::REG_STEP_LIMIT: rev_limit = value[7:0];
				mstg_pkg::REG_INIT_DIV: begin
					sweep_div = value[7:0];
					if (!swept)
						for (i = 0; i < NCH; i++)
							div_q[i] = sweep_div;
				end
				default: ;
			endcase
		endfunction

		function void advance_tick();
			int i;
			logic [30:0] d;
			for (i = 0; i < NCH; i++) begin
				d = (div_q[i] == 0) ? 31'd1 : 31'(div_q[i]);
				if (on_q[i] && (tick_cnt % d) == 0) begin
					step_q[i] = ~step_q[i];
					if (swept && cnt_q[i] > 10'(rev_limit)) begin
						dir_q[i] = ~dir_q[i];
						cnt_q[i] = '0;
					end
					if (cnt_q[i] != 10'd1023)
						cnt_q[i] = cnt_q[i] + 10'd1;
				end
			end
			tick_cnt = tick_cnt + 31'd1;
			if (!swept && tick_cnt > 31'(sweep_ticks)) begin
				swept = 1'b1;
				for (i = 0; i < NCH; i++) begin
					div_q[i] = 8'd1;
					on_q[i] = 1'b0;
					cnt_q[i] = '0;
					dir_q[i] = ~dir_q[i];
				end
			end
		endfunction

		function void take_item(logic c, logic [5:0] n, logic [6:0] ch, logic on_in);
			levels_t lv;
			if (c == CMD_TICK) begin
				advance_tick();
			end else if (ch < NCH) begin
				div_q[ch] = (n < 60) ? PITCH_DIV[n] : 8'd1;
				on_q[ch] = on_in;
			end
			lv.steps = step_q;
			lv.dirs = dir_q;
			lv.done = swept;
			levels_q.push_back(lv);
		endfunction

		function void compare_levels(logic [9:0] s, logic [9:0] d, logic st);
			levels_t lv;
			if (levels_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result step %h dir %h started %b", $time, s, d, st);
				return;
			end
			lv = levels_q.pop_front();
			if (s !== lv.steps) begin
				errors++;
				$display("%0t: step_levels expected %h actual %h", $time, lv.steps, s);
			end
			if (d !== lv.dirs) begin
				errors++;
				$display("%0t: dir_levels expected %h actual %h", $time, lv.dirs, d);
			end
			if (st !== lv.done) begin
				errors++;
				$display("%0t: started expected %b actual %b", $time, lv.done, st);
			end
		endfunction

		function int pending();
			return levels_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [mstg_pkg::ADDR_W-1:0] paddr = '0;
	logic [mstg_pkg::DATA_W-1:0] pwdata = '0;
	logic [mstg_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = 1'b0;
	logic [mstg_pkg::NOTE_W-1:0] note = '0;
	logic [mstg_pkg::CHAN_IN_W-1:0] channel = '0;
	logic turn_on = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [mstg_pkg::LEVEL_W-1:0] step_levels;
	logic [mstg_pkg::LEVEL_W-1:0] dir_levels;
	logic started;

	tone_scoreboard sb = new();
	int cycle_cnt = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	int out_hold = 0;

	multichannel_stepper_tone_generator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.note(note),
		.channel(channel),
		.turn_on(turn_on),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.step_levels(step_levels),
		.dir_levels(dir_levels),
		.started(started)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == TIMEOUT) begin
			$display("multichannel_stepper_tone_generator_unit_test NOT OK");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 60);
		return $urandom_range(100, 200);
	endfunction

	// result side: random stalls, check on every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.compare_levels(step_levels, dir_levels, started);
		if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < out_idle_pct)
				out_hold = pick_gap();
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_item(input logic c, input logic [mstg_pkg::NOTE_W-1:0] n,
			input logic [mstg_pkg::CHAN_IN_W-1:0] ch, input logic on_in);
		int gap;
		cmd <= c;
		note <= n;
		channel <= ch;
		turn_on <= on_in;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_item(c, n, ch, on_in);
		gap = ($urandom_range(0, 99) < in_idle_pct) ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_tick();
		send_item(CMD_TICK, mstg_pkg::NOTE_W'($urandom), mstg_pkg::CHAN_IN_W'($urandom),
			1'($urandom));
	endtask

	task automatic send_random_item();
		logic [mstg_pkg::NOTE_W-1:0] n;
		logic [mstg_pkg::CHAN_IN_W-1:0] ch;
		if ($urandom_range(0, 99) < 35) begin
			n = ($urandom_range(0, 1) == 0) ? mstg_pkg::NOTE_W'($urandom_range(20, 57))
			                                : mstg_pkg::NOTE_W'($urandom_range(0, 63));
			ch = ($urandom_range(0, 99) < 85)
				? mstg_pkg::CHAN_IN_W'($urandom_range(0, NCH - 1))
				: mstg_pkg::CHAN_IN_W'($urandom_range(0, 127));
			send_item(CMD_NOTE, n, ch, $urandom_range(0, 99) < 80);
		end else begin
			send_tick();
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int ph;
		int k;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// startup sweep with a zero divider on every channel
		write_reg(mstg_pkg::REG_INIT_TICKS, 32'd12);
		write_reg(mstg_pkg::REG_STEP_LIMIT, 32'd0);
		write_reg(mstg_pkg::REG_INIT_DIV, 32'd0);
		repeat (3) send_tick();
		send_item(CMD_NOTE, 6'd21, 7'd0, 1'b1);
		send_item(CMD_NOTE, 6'd59, 7'd9, 1'b0);
		send_item(CMD_NOTE, 6'd63, 7'd3, 1'b1);
		send_item(CMD_NOTE, 6'd0, 7'd10, 1'b0);
		send_item(CMD_NOTE, 6'd45, 7'd127, 1'b0);
		repeat (2) send_tick();
		wait_idle();

		// divider reload during startup, then end the sweep early
		write_reg(mstg_pkg::REG_INIT_DIV, 32'd255);
		repeat (3) send_tick();
		wait_idle();
		write_reg(mstg_pkg::REG_INIT_TICKS, 32'd0);
		send_tick();
		send_item(CMD_NOTE, 6'd20, 7'd1, 1'b1);
		send_item(CMD_NOTE, 6'd57, 7'd2, 1'b1);
		send_item(CMD_NOTE, 6'd58, 7'd5, 1'b1);
		send_item(CMD_NOTE, 6'd40, 7'd9, 1'b0);
		send_item(CMD_NOTE, 6'd63, 7'd4, 1'b1);
		repeat (4) send_tick();
		wait_idle();

		write_reg(mstg_pkg::REG_INIT_TICKS, 32'd65535);
		write_reg(mstg_pkg::REG_STEP_LIMIT, 32'd255);
		write_reg(mstg_pkg::REG_INIT_DIV, 32'd1);
		write_reg(REG_NONE, $urandom);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: write_reg(mstg_pkg::REG_STEP_LIMIT, 32'd1);
				1: write_reg(mstg_pkg::REG_STEP_LIMIT, 32'd255);
				2: write_reg(mstg_pkg::REG_STEP_LIMIT, $urandom_range(2, 12));
				3: write_reg(mstg_pkg::REG_STEP_LIMIT, $urandom_range(1, 255));
				default: write_reg(mstg_pkg::REG_STEP_LIMIT, $urandom_range(1, 40));
			endcase
			write_reg(mstg_pkg::REG_INIT_DIV, $urandom_range(1, 255));
			write_reg(mstg_pkg::REG_INIT_TICKS, $urandom_range(0, 65535));
			in_idle_pct = (ph == 0) ? 0 : $urandom_range(10, 60);
			out_idle_pct = (ph == 0) ? 0 : $urandom_range(10, 60);
			for (k = 0; k < PHASE_ITEMS; k++)
				send_random_item();
		end

		wait_idle();
		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("multichannel_stepper_tone_generator_unit_test OK");
		else
			$display("multichannel_stepper_tone_generator_unit_test NOT OK");
		$finish;
	end

endmodule
